FILE: rtl/pid_position_step_top_defines.svh
// Assertion macros used by the port-level checker of the position PID step block.
`ifndef PID_POSITION_STEP_TOP_DEFINES_SVH
`define PID_POSITION_STEP_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PPS_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pps assertion failed");

// Next-cycle implication, disabled while reset is high.
`define PPS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pps assertion failed");

// Next-cycle implication that also holds across reset.
`define PPS_ASSERT_ALWAYS(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pps assertion failed");

`endif

FILE: rtl/pps_pkg.sv
// Types and constants of the position PID step block.
package pps_pkg;

  localparam int POS_W     = 24;
  localparam int ERR_W     = POS_W + 1;
  localparam int DER_W     = ERR_W + 1;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 8;
  localparam int PWR_W     = 32;
  localparam int INTO_W    = 16;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  // Holds the sum of the three gain products for every supported fraction width.
  localparam int SUM_W     = 44;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KI     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KD     = 3'd4;

  localparam logic [GAIN_W-1:0] KP_RESET = 16'd1280;

  typedef struct packed {
    logic signed [POS_W-1:0] measured_position;
    logic                    first_sample;
  } in_t;

  typedef struct packed {
    logic signed [PWR_W-1:0]  drive_power;
    logic                     power_saturated;
    logic signed [INTO_W-1:0] integral_value;
  } out_t;

endpackage

FILE: rtl/pps_terms.sv
// Error, integral reset and clamp rules, and derivative for one sample.
module pps_terms import pps_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  logic signed [POS_W-1:0]           target,
  input  logic                              dir_pos,
  input  logic signed [POS_W-1:0]           meas,
  input  logic                              first,
  input  logic signed [FRACTION_BITS+7:0]   acc,
  input  logic signed [ERR_W-1:0]           prev,
  output logic signed [ERR_W-1:0]           err,
  output logic signed [FRACTION_BITS+7:0]   integ,
  output logic signed [DER_W-1:0]           deriv
);

  localparam int INT_W  = FRACTION_BITS + 8;
  localparam int SUMI_W = ((INT_W > ERR_W) ? INT_W : ERR_W) + 1;
  localparam logic signed [SUMI_W-1:0] LIMIT = SUMI_W'(100) << FRACTION_BITS;

  logic signed [INT_W-1:0]  acc_eff;
  logic signed [ERR_W-1:0]  prev_eff;
  logic signed [SUMI_W-1:0] err_x;
  logic signed [SUMI_W-1:0] sumi;
  logic signed [SUMI_W-1:0] integ_x;
  logic                     zero_it;

  assign err      = ERR_W'(target) - ERR_W'(meas);
  // A new move starts from a clean integral and a zero derivative.
  assign acc_eff  = first ? '0 : acc;
  assign prev_eff = first ? err : prev;
  assign err_x    = SUMI_W'(err);
  assign sumi     = SUMI_W'(acc_eff) + err_x;
  assign deriv    = DER_W'(err) - DER_W'(prev_eff);

  always_comb begin
    if (dir_pos) begin
      zero_it = (err_x <= 0) || (err_x >= LIMIT);
    end else begin
      zero_it = (err_x >= 0) || (err_x <= -LIMIT);
    end
    if (zero_it) begin
      integ_x = '0;
    end else if (dir_pos && (sumi > LIMIT)) begin
      integ_x = LIMIT;
    end else if (!dir_pos && (sumi < -LIMIT)) begin
      integ_x = -LIMIT;
    end else begin
      integ_x = sumi;
    end
  end

  // The clamped integral always fits within the stored width.
  assign integ = integ_x[INT_W-1:0];

endmodule

FILE: rtl/pps_power.sv
// Sum of the gain products, floor shift, saturation and result word assembly.
module pps_power import pps_pkg::*; #(
  parameter int INT_W = 16
) (
  input  logic signed [ERR_W+GAIN_W:0] prod_e,
  input  logic signed [INT_W+GAIN_W:0] prod_i,
  input  logic signed [DER_W+GAIN_W:0] prod_d,
  input  logic signed [INT_W-1:0]      integ,
  output out_t                         result
);

  localparam int IXW = (INT_W > INTO_W) ? INT_W : INTO_W;
  localparam logic signed [SUM_W-1:0] PMAX = SUM_W'(32'h7fff_ffff);
  localparam logic signed [SUM_W-1:0] PMIN = -PMAX - SUM_W'(1);

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] shifted;
  logic signed [IXW-1:0]   integ_x;

  assign sum     = SUM_W'(prod_e) + SUM_W'(prod_i) + SUM_W'(prod_d);
  // Arithmetic shift rounds toward minus infinity.
  assign shifted = sum >>> GAIN_FRAC;
  assign integ_x = IXW'(integ);

  always_comb begin
    result.integral_value = integ_x[INTO_W-1:0];
    if (shifted > PMAX) begin
      result.drive_power     = PMAX[PWR_W-1:0];
      result.power_saturated = 1'b1;
    end else if (shifted < PMIN) begin
      result.drive_power     = PMIN[PWR_W-1:0];
      result.power_saturated = 1'b1;
    end else begin
      result.drive_power     = shifted[PWR_W-1:0];
      result.power_saturated = 1'b0;
    end
  end

endmodule

FILE: rtl/pid_position_step_top.sv
// Top level of the position PID step block: config registers, state and pipeline.
//
//   Channel   Direction  Handshake            Word
//   cfg       in         cfg_we               cfg_index, cfg_data
//   in        in         in_valid, in_ready   in_word (in_t)
//   out       out        out_valid, out_ready out_word (out_t)
//
// One word is taken per cycle while in_ready is high; its result leaves through the stages below.
// The stages are input register, term register (error, integral, derivative),
// product register (one multiplier per gain) and result register.
// Integral and previous error update as a word leaves the input register.
// A stalled output backs up stage by stage; empty stages keep taking words.
// Synchronous reset empties the pipeline and restores registers and state.
module pid_position_step_top import pps_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_word
);

  localparam int INT_W = FRACTION_BITS + 8;
  localparam int PE_W  = ERR_W + GAIN_W + 1;
  localparam int PI_W  = INT_W + GAIN_W + 1;
  localparam int PD_W  = DER_W + GAIN_W + 1;

  // Configuration registers.
  logic signed [POS_W-1:0] target;
  logic                    dir_pos;
  logic [GAIN_W-1:0]       kp;
  logic [GAIN_W-1:0]       ki;
  logic [GAIN_W-1:0]       kd;

  // Controller state.
  logic signed [INT_W-1:0] acc;
  logic signed [ERR_W-1:0] prev;

  // Pipeline registers.
  logic                    v1, v2, v3;
  in_t                     s1;
  logic signed [ERR_W-1:0] s2_err;
  logic signed [INT_W-1:0] s2_int;
  logic signed [DER_W-1:0] s2_der;
  logic signed [PE_W-1:0]  s3_pe;
  logic signed [PI_W-1:0]  s3_pi;
  logic signed [PD_W-1:0]  s3_pd;
  logic signed [INT_W-1:0] s3_int;

  logic free_o, free3, free2, free1;

  logic signed [ERR_W-1:0] err_next;
  logic signed [INT_W-1:0] int_next;
  logic signed [DER_W-1:0] der_next;
  out_t                    result;

  assign free_o   = !out_valid || out_ready;
  assign free3    = !v3 || free_o;
  assign free2    = !v2 || free3;
  assign free1    = !v1 || free2;
  assign in_ready = free1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target  <= '0;
      dir_pos <= 1'b1;
      kp      <= KP_RESET;
      ki      <= '0;
      kd      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET: target  <= cfg_data[POS_W-1:0];
        REG_DIR:    dir_pos <= cfg_data[0];
        REG_KP:     kp      <= cfg_data[GAIN_W-1:0];
        REG_KI:     ki      <= cfg_data[GAIN_W-1:0];
        REG_KD:     kd      <= cfg_data[GAIN_W-1:0];
        default:    ;
      endcase
    end
  end

  pps_terms #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_terms (
    .target (target),
    .dir_pos(dir_pos),
    .meas   (s1.measured_position),
    .first  (s1.first_sample),
    .acc    (acc),
    .prev   (prev),
    .err    (err_next),
    .integ  (int_next),
    .deriv  (der_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
      acc       <= '0;
      prev      <= '0;
    end else begin
      if (free1) begin
        v1 <= in_valid;
      end
      if (free2) begin
        v2 <= v1;
        if (v1) begin
          acc  <= int_next;
          prev <= err_next;
        end
      end
      if (free3) begin
        v3 <= v2;
      end
      if (free_o) begin
        out_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free1 && in_valid) begin
      s1 <= in_word;
    end
    if (free2 && v1) begin
      s2_err <= err_next;
      s2_int <= int_next;
      s2_der <= der_next;
    end
    if (free3 && v2) begin
      s3_pe  <= s2_err * $signed({1'b0, kp});
      s3_pi  <= s2_int * $signed({1'b0, ki});
      s3_pd  <= s2_der * $signed({1'b0, kd});
      s3_int <= s2_int;
    end
    if (free_o && v3) begin
      out_word <= result;
    end
  end

  pps_power #(
    .INT_W(INT_W)
  ) u_power (
    .prod_e(s3_pe),
    .prod_i(s3_pi),
    .prod_d(s3_pd),
    .integ (s3_int),
    .result(result)
  );

endmodule

FILE: rtl/pps_checker.sv
// Port-level checker for the position PID step block and its bind.
`include "pid_position_step_top_defines.svh"

module pps_checker import pps_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_word
);

  // A waiting result must neither vanish nor change.
  `PPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `PPS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_word))

  // A saturated word carries one of the two rails.
  `PPS_ASSERT_NOW(a_sat_rail, out_valid && out_word.power_saturated,
    (out_word.drive_power == 32'sh7fff_ffff) || (out_word.drive_power == 32'sh8000_0000))

  // Reset leaves no result behind.
  `PPS_ASSERT_ALWAYS(a_rst_empty, rst, !out_valid)

  // An empty output register with no word offered leaves the input side unblocked.
  `PPS_ASSERT_NEXT(a_ready_free, !out_valid && !in_valid, in_ready)

endmodule

bind pid_position_step_top pps_checker u_pps_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_word (out_word)
);

FILE: sim/pid_power_checker.sv
// Checker for the position PID step block: tracks config writes, predicts each result, compares.
module pid_power_checker import pps_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_t                  in_word,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_t                 out_word,
  output int                   mismatches,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint WINDUP  = longint'(100) << FRACTION_BITS;
  localparam longint PWR_MAX = (longint'(1) << (PWR_W - 1)) - 1;
  localparam longint PWR_MIN = -(longint'(1) << (PWR_W - 1));

  logic signed [POS_W-1:0] goal;
  logic                    dir_pos;
  logic [GAIN_W-1:0]       kp, ki, kd;
  longint                  integral_acc;
  longint                  last_error;

  out_t power_q[$];
  int   fail_cnt = 0;
  int   q_len = 0;
  int   word_no = 0;

  assign mismatches  = fail_cnt;
  assign outstanding = q_len;

  // Works out the result of one word and advances the integral and error history.
  function automatic out_t next_power(in_t w);
    longint err, integ, deriv, sum, pwr;
    out_t   r;
    err = longint'(goal) - longint'($signed(w.measured_position));
    if (w.first_sample) begin
      last_error   = err;
      integral_acc = 0;
    end
    integ = integral_acc + err;
    // Zero the integral once the error reaches or crosses zero against the move,
    // or while it is still far from the goal in the move direction.
    if (dir_pos ? (err <= 0) : (err >= 0)) integ = 0;
    if (dir_pos ? (err >= WINDUP) : (err <= -WINDUP)) integ = 0;
    if (dir_pos && integ > WINDUP) integ = WINDUP;
    if (!dir_pos && integ < -WINDUP) integ = -WINDUP;
    deriv = err - last_error;
    sum = err * longint'(kp) + integ * longint'(ki) + deriv * longint'(kd);
    pwr = sum >>> GAIN_FRAC;
    r.power_saturated = 1'b0;
    if (pwr > PWR_MAX) begin
      pwr = PWR_MAX;
      r.power_saturated = 1'b1;
    end
    if (pwr < PWR_MIN) begin
      pwr = PWR_MIN;
      r.power_saturated = 1'b1;
    end
    r.drive_power    = pwr[PWR_W-1:0];
    r.integral_value = integ[INTO_W-1:0];
    integral_acc = integ;
    last_error   = err;
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    fail_cnt++;
    $display("%0t: result word %0d, %s is %0d, expected %0d", $time, word_no, field, got, want);
  endtask

  always @(posedge clk) begin : monitor
    out_t want;
    if (rst) begin
      goal         = '0;
      dir_pos      = 1'b1;
      kp           = KP_RESET;
      ki           = '0;
      kd           = '0;
      integral_acc = 0;
      last_error   = 0;
      power_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TARGET: goal    = cfg_data[POS_W-1:0];
          REG_DIR:    dir_pos = cfg_data[0];
          REG_KP:     kp      = cfg_data[GAIN_W-1:0];
          REG_KI:     ki      = cfg_data[GAIN_W-1:0];
          REG_KD:     kd      = cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) power_q.push_back(next_power(in_word));
      if (out_valid && out_ready) begin
        if (power_q.size() == 0) begin
          report_mismatch("unexpected word, drive_power",
                          longint'($signed(out_word.drive_power)), longint'(0));
        end else begin
          want = power_q.pop_front();
          if (out_word.drive_power !== want.drive_power)
            report_mismatch("drive_power", longint'($signed(out_word.drive_power)),
                            longint'($signed(want.drive_power)));
          if (out_word.power_saturated !== want.power_saturated)
            report_mismatch("power_saturated", longint'(out_word.power_saturated),
                            longint'(want.power_saturated));
          if (out_word.integral_value !== want.integral_value)
            report_mismatch("integral_value", longint'($signed(out_word.integral_value)),
                            longint'($signed(want.integral_value)));
        end
        word_no++;
      end
    end
    q_len = power_q.size();
  end

endmodule

FILE: sim/tb.sv
// Testbench top for the position PID step block: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pps_pkg::*;

  localparam int     FRACTION_BITS = 8;
  localparam int     REG_COUNT     = 5;
  localparam int     RANDOM_PHASES = 8;
  localparam int     PHASE_WORDS   = 60;
  localparam int     QUIET_PHASE   = 2;
  localparam int     HOLD_PHASE    = 4;
  localparam int     HOLD_CYCLES   = 120;
  localparam longint WINDUP  = longint'(100) << FRACTION_BITS;
  localparam longint POS_MAX = (longint'(1) << (POS_W - 1)) - 1;
  localparam longint POS_MIN = -(longint'(1) << (POS_W - 1));

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_t                  in_word = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_word;
  int                   mismatches;
  int                   outstanding;

  bit     idle_on = 1'b1;
  bit     stall_on = 1'b1;
  int     phase_no = -1;
  longint goal = 0;
  bit     dir_pos = 1'b1;

  always #2 clk = ~clk;

  pid_position_step_top #(.FRACTION_BITS(FRACTION_BITS)) dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
  );

  pid_power_checker #(.FRACTION_BITS(FRACTION_BITS)) power_chk (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // Receiver: random stalls, and one long hold-off that lets the pipeline fill.
  initial begin : receiver
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && phase_no == HOLD_PHASE) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(stall_on && ($urandom_range(99) < 18));
      end
    end
  end

  task automatic send_word(in_t w);
    if (idle_on && ($urandom_range(99) < 18)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sends the measured position that gives the wanted error against the current goal.
  task automatic send_error(longint err, bit first);
    longint meas;
    in_t    w;
    meas = goal - err;
    if (meas > POS_MAX) meas = POS_MAX;
    if (meas < POS_MIN) meas = POS_MIN;
    w.measured_position = meas[POS_W-1:0];
    w.first_sample      = first;
    send_word(w);
  endtask

  // Stops sending and waits until every result is out.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(longint target, bit dir, logic [GAIN_W-1:0] kp,
                              logic [GAIN_W-1:0] ki, logic [GAIN_W-1:0] kd);
    logic [CFG_W-1:0] vals[REG_COUNT];
    logic [CFG_W-1:0] noise;
    noise = CFG_W'($urandom);
    // Unused upper bits carry random values; the block must ignore them.
    vals[REG_TARGET] = target[CFG_W-1:0];
    vals[REG_DIR]    = {noise[CFG_W-1:1], dir};
    vals[REG_KP]     = {noise[CFG_W-1:GAIN_W], kp};
    vals[REG_KI]     = {noise[CFG_W-1:GAIN_W], ki};
    vals[REG_KD]     = {noise[CFG_W-1:GAIN_W], kd};
    for (int i = 0; i < REG_COUNT; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    // A write past the register list must change nothing.
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, REG_COUNT));
    cfg_data  <= CFG_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    goal    = target;
    dir_pos = dir;
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return GAIN_W'($urandom_range(1023));
      default: return GAIN_W'($urandom_range(65535));
    endcase
  endfunction

  // One move: a first word, then errors closing in on the goal, with some noise.
  task automatic run_move(int n);
    longint      e, sgn;
    int          r;
    in_t         w;
    logic [31:0] rnd;
    sgn = dir_pos ? 1 : -1;
    e = sgn * longint'($urandom_range(40000));
    send_error(e, 1'b1);
    for (int k = 1; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        rnd = $urandom;
        w = rnd[$bits(in_t)-1:0];
        w.first_sample = ($urandom_range(9) == 0);
        send_word(w);
      end else if (r < 14) begin
        e = longint'($urandom_range(60000)) - 30000;
        send_error(e, $urandom_range(3) == 0);
      end else begin
        e = e - sgn * longint'($urandom_range(3000));
        send_error(e, 1'b0);
      end
    end
  endtask

  initial begin : stimulus
    int     count, n;
    longint target;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Values after reset, with the position extremes.
    send_error(0, 1'b1);
    send_error(100, 1'b0);
    send_error(-POS_MAX, 1'b0);
    send_error(-POS_MIN, 1'b0);

    // Largest gains: saturation both ways, then the integral edges of a positive move.
    settle();
    write_config(POS_MAX, 1'b1, '1, '1, '1);
    send_error(POS_MAX - POS_MIN, 1'b1);
    send_error(WINDUP - 1, 1'b0);
    send_error(WINDUP, 1'b0);
    send_error(20000, 1'b0);
    send_error(20000, 1'b0);
    send_error(0, 1'b0);
    send_error(-1, 1'b0);

    // The same edges for a negative move, leaving a negative integral behind.
    settle();
    write_config(POS_MIN, 1'b0, GAIN_W'(256), GAIN_W'(256), GAIN_W'(256));
    send_error(POS_MIN - POS_MAX, 1'b1);
    send_error(-(WINDUP - 1), 1'b0);
    send_error(-WINDUP, 1'b0);
    send_error(-20000, 1'b0);
    send_error(-20000, 1'b0);
    send_error(0, 1'b0);
    send_error(-20000, 1'b0);

    // Direction flips mid-move; the stored integral carries over.
    settle();
    write_config(0, 1'b1, GAIN_W'(256), GAIN_W'(256), GAIN_W'(256));
    send_error(10000, 1'b0);
    send_error(1000, 1'b0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      phase_no = p;
      idle_on  = !(p == QUIET_PHASE || p == HOLD_PHASE);
      stall_on = (p != QUIET_PHASE);
      if ($urandom_range(3) == 0) target = $urandom_range(1) ? POS_MAX : POS_MIN;
      else target = longint'($urandom_range(8000000)) - 4000000;
      if (p == 0) write_config(target, 1'($urandom_range(1)), '1, '1, '1);
      else if (p == 1) write_config(target, 1'($urandom_range(1)), '0, '0, '0);
      else write_config(target, 1'($urandom_range(1)), pick_gain(), pick_gain(), pick_gain());
      count = 0;
      while (count < PHASE_WORDS) begin
        n = $urandom_range(15, 3);
        run_move(n);
        count += n;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/pps_pkg.sv
rtl/pps_terms.sv
rtl/pps_power.sv
rtl/pid_position_step_top.sv
rtl/pps_checker.sv
sim/pid_power_checker.sv
sim/tb.sv
